// ----- hdl/ccs_pkg.sv -----
// Shared constants and types for the cubic curve subdivider.
package ccs_pkg;

    localparam int FRAC_PER_LEVEL = 3;

    localparam logic [1:0] SEEN_NONE = 2'd0;
    localparam logic [1:0] SEEN_ONE  = 2'd1;
    localparam logic [1:0] SEEN_MORE = 2'd2;

    typedef struct packed {
        logic clear;
        logic bypass;
    } cfg_t;

    typedef struct packed {
        logic sm;
        logic mid;
        logic self_pt;
        logic self_last;
    } job_t;

endpackage

// ----- hdl/ccs_cell.sv -----
// One subdivision cell: keeps the last two points of a curve and emits up to three words per point.
module ccs_cell #(
    parameter int W = 25
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ccs_pkg::cfg_t        cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [W-1:0]  in_x,
    input  logic signed [W-1:0]  in_y,
    input  logic                 in_last,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [W-1:0]  out_x,
    output logic signed [W-1:0]  out_y,
    output logic                 out_last
);

    logic signed [W-1:0] older_x_reg, older_y_reg, newer_x_reg, newer_y_reg;
    logic signed [W-1:0] older_x_next, older_y_next, newer_x_next, newer_y_next;
    logic [1:0]          seen_reg, seen_next;
    ccs_pkg::job_t       job_reg, job_next;

    logic signed [W-1:0] sm_x_reg, sm_y_reg, mid_x_reg, mid_y_reg, self_x_reg, self_y_reg;
    logic signed [W-1:0] sm_x, sm_y, mid_x, mid_y;

    logic                out_valid_reg, out_valid_next;
    logic signed [W-1:0] out_x_reg, out_y_reg, out_x_next, out_y_next;
    logic                out_last_reg, out_last_next;

    logic                acc, load_ok;

    logic signed [W+2:0] sum_x, sum_y;
    logic signed [W:0]   half_x, half_y;

    assign in_ready = (job_reg == '0);
    assign acc      = in_valid && in_ready;
    assign load_ok  = !out_valid_reg || out_ready;

    // smoothed vertex (o + 6n + p) / 8 and edge midpoint (n + p) / 2, exact
    assign sum_x = {{3{older_x_reg[W-1]}}, older_x_reg}
                 + {newer_x_reg[W-1], newer_x_reg, 2'b00}
                 + {{2{newer_x_reg[W-1]}}, newer_x_reg, 1'b0}
                 + {{3{in_x[W-1]}}, in_x};
    assign sum_y = {{3{older_y_reg[W-1]}}, older_y_reg}
                 + {newer_y_reg[W-1], newer_y_reg, 2'b00}
                 + {{2{newer_y_reg[W-1]}}, newer_y_reg, 1'b0}
                 + {{3{in_y[W-1]}}, in_y};
    assign half_x = {newer_x_reg[W-1], newer_x_reg} + {in_x[W-1], in_x};
    assign half_y = {newer_y_reg[W-1], newer_y_reg} + {in_y[W-1], in_y};
    assign sm_x  = sum_x[W+2:3];
    assign sm_y  = sum_y[W+2:3];
    assign mid_x = half_x[W:1];
    assign mid_y = half_y[W:1];

    always_comb
    begin
        older_x_next   = older_x_reg;
        older_y_next   = older_y_reg;
        newer_x_next   = newer_x_reg;
        newer_y_next   = newer_y_reg;
        seen_next      = seen_reg;
        job_next       = job_reg;
        out_valid_next = out_valid_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_last_next  = out_last_reg;

        // advance the output word: smoothed vertex, then midpoint, then the point itself
        if (load_ok)
        begin
            priority if (job_reg.sm)
            begin
                out_valid_next = 1'b1;
                out_x_next     = sm_x_reg;
                out_y_next     = sm_y_reg;
                out_last_next  = 1'b0;
                job_next.sm    = 1'b0;
            end
            else if (job_reg.mid)
            begin
                out_valid_next = 1'b1;
                out_x_next     = mid_x_reg;
                out_y_next     = mid_y_reg;
                out_last_next  = 1'b0;
                job_next.mid   = 1'b0;
            end
            else if (job_reg.self_pt)
            begin
                out_valid_next     = 1'b1;
                out_x_next         = self_x_reg;
                out_y_next         = self_y_reg;
                out_last_next      = job_reg.self_last;
                job_next.self_pt   = 1'b0;
                job_next.self_last = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end

        if (acc)
        begin
            job_next = '0;
            if (cfg.bypass)
            begin
                job_next.self_pt   = 1'b1;
                job_next.self_last = in_last;
            end
            else
            begin
                unique case (seen_reg)
                    ccs_pkg::SEEN_ONE:
                    begin
                        if (in_last)
                        begin
                            job_next.self_pt   = 1'b1;
                            job_next.self_last = 1'b1;
                            seen_next          = ccs_pkg::SEEN_NONE;
                        end
                        else
                        begin
                            job_next.mid = 1'b1;
                            older_x_next = newer_x_reg;
                            older_y_next = newer_y_reg;
                            newer_x_next = in_x;
                            newer_y_next = in_y;
                            seen_next    = ccs_pkg::SEEN_MORE;
                        end
                    end
                    ccs_pkg::SEEN_MORE:
                    begin
                        job_next.sm  = 1'b1;
                        job_next.mid = 1'b1;
                        older_x_next = newer_x_reg;
                        older_y_next = newer_y_reg;
                        newer_x_next = in_x;
                        newer_y_next = in_y;
                        if (in_last)
                        begin
                            job_next.self_pt   = 1'b1;
                            job_next.self_last = 1'b1;
                            seen_next          = ccs_pkg::SEEN_NONE;
                        end
                    end
                    default:
                    begin
                        job_next.self_pt   = 1'b1;
                        job_next.self_last = in_last;
                        if (in_last)
                        begin
                            seen_next = ccs_pkg::SEEN_NONE;
                        end
                        else
                        begin
                            newer_x_next = in_x;
                            newer_y_next = in_y;
                            seen_next    = ccs_pkg::SEEN_ONE;
                        end
                    end
                endcase
            end
        end

        if (cfg.clear)
        begin
            seen_next = ccs_pkg::SEEN_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            older_x_reg   <= '0;
            older_y_reg   <= '0;
            newer_x_reg   <= '0;
            newer_y_reg   <= '0;
            seen_reg      <= ccs_pkg::SEEN_NONE;
            job_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            older_x_reg   <= older_x_next;
            older_y_reg   <= older_y_next;
            newer_x_reg   <= newer_x_next;
            newer_y_reg   <= newer_y_next;
            seen_reg      <= seen_next;
            job_reg       <= job_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_x_reg    <= out_x_next;
        out_y_reg    <= out_y_next;
        out_last_reg <= out_last_next;
        if (acc)
        begin
            sm_x_reg   <= sm_x;
            sm_y_reg   <= sm_y;
            mid_x_reg  <= mid_x;
            mid_y_reg  <= mid_y;
            self_x_reg <= in_x;
            self_y_reg <= in_y;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_last  = out_last_reg;

`ifndef SYNTHESIS
    a_accept_makes_work: assert property (@(posedge clk) disable iff (!rst_n)
        acc |=> (job_reg != '0))
        else $error("accepted point left no pending word");

    a_last_is_final: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_last_reg) |-> (!job_reg.sm && !job_reg.mid))
        else $error("curve end emitted ahead of pending words");

    a_clear_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        cfg.clear |=> (seen_reg == ccs_pkg::SEEN_NONE))
        else $error("mode write did not restart the curve");
`endif

endmodule

// ----- hdl/cubic_curve_subdivider.sv -----
// Top level: input scaling, mode register and the chain of subdivision cells.
// A cell takes a new point only once every word of its previous point has moved to its output register,
// and emits one word per cycle while the downstream side is ready; in cubic mode the last cell sets the pace,
// taking 2^(LEVELS-1) points and emitting 2^LEVELS words per input point, plus up to 2^LEVELS-1 extra
// words at a curve end. Reset (rst_n, async, active low): empties all cells, sets cubic mode.
module cubic_curve_subdivider #(
    parameter int LEVELS     = 3,
    parameter int COORD_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_wdata,     // cubic_mode
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [((2*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,  // point_x, point_y
    input  logic                s_axis_tlast,  // point_last
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [((2*(COORD_BITS+ccs_pkg::FRAC_PER_LEVEL*LEVELS)+7)/8)*8-1:0]
                                m_axis_tdata,  // out_x, out_y
    output logic                m_axis_tlast   // out_last
);

    localparam int FRAC       = ccs_pkg::FRAC_PER_LEVEL * LEVELS;
    localparam int W          = COORD_BITS + FRAC;
    localparam int OUT_DATA_W = ((2*W+7)/8)*8;

    logic          mode_reg;
    ccs_pkg::cfg_t cfg;

    logic                valid_c [LEVELS+1];
    logic                ready_c [LEVELS+1];
    logic signed [W-1:0] x_c     [LEVELS+1];
    logic signed [W-1:0] y_c     [LEVELS+1];
    logic                last_c  [LEVELS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            mode_reg <= cfg_wdata;
        end
    end

    assign cfg.clear  = cfg_we;
    assign cfg.bypass = !mode_reg;

    assign valid_c[0]    = s_axis_tvalid;
    assign s_axis_tready = ready_c[0];
    assign x_c[0]        = {s_axis_tdata[COORD_BITS-1:0], {FRAC{1'b0}}};
    assign y_c[0]        = {s_axis_tdata[2*COORD_BITS-1:COORD_BITS], {FRAC{1'b0}}};
    assign last_c[0]     = s_axis_tlast;

    for (genvar i = 0; i < LEVELS; i++)
    begin : g_cell
        ccs_cell #(
            .W (W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cfg       (cfg),
            .in_valid  (valid_c[i]),
            .in_ready  (ready_c[i]),
            .in_x      (x_c[i]),
            .in_y      (y_c[i]),
            .in_last   (last_c[i]),
            .out_valid (valid_c[i+1]),
            .out_ready (ready_c[i+1]),
            .out_x     (x_c[i+1]),
            .out_y     (y_c[i+1]),
            .out_last  (last_c[i+1])
        );
    end

    assign m_axis_tvalid   = valid_c[LEVELS];
    assign ready_c[LEVELS] = m_axis_tready;
    assign m_axis_tdata    = OUT_DATA_W'({y_c[LEVELS], x_c[LEVELS]});
    assign m_axis_tlast    = last_c[LEVELS];

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for the cubic curve subdivider: stream traffic, scoreboard, checks.
module tb_top;

    localparam int LEVELS      = 3;
    localparam int COORD_BITS  = 16;
    localparam int FRAC_BITS   = ccs_pkg::FRAC_PER_LEVEL * LEVELS;
    localparam int OUT_BITS    = COORD_BITS + FRAC_BITS;
    localparam int IN_W        = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_W       = ((2 * OUT_BITS + 7) / 8) * 8;
    localparam longint FRAC_SCALE = longint'(1) << FRAC_BITS;
    localparam int SETTLE_CYCLES = 4 * LEVELS;
    localparam int HOLD_CYCLES   = 300;

    typedef struct {
        longint x;
        longint y;
        bit     last;
    } curve_pt_t;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] x;
        logic signed [OUT_BITS-1:0] y;
        logic                       last;
    } curve_word_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic                 cfg_wdata;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [IN_W-1:0]      s_axis_tdata;   // point_x, point_y
    logic                 s_axis_tlast;   // point_last
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [OUT_W-1:0]     m_axis_tdata;   // out_x, out_y
    logic                 m_axis_tlast;   // out_last

    // Predictor state, one entry per subdivision stage
    logic                 mode_cubic;
    longint               tail_x [LEVELS];
    longint               tail_y [LEVELS];
    longint               head_x [LEVELS];
    longint               head_y [LEVELS];
    logic [1:0]           seen   [LEVELS];

    curve_word_t          pending_words[$];

    int                   points_sent;
    int                   curves_sent;
    int                   words_checked;
    int                   errors;
    bit                   gaps_on;
    logic                 stall_on;
    int                   hold_reqs;

    cubic_curve_subdivider #(
        .LEVELS     (LEVELS),
        .COORD_BITS (COORD_BITS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    initial
    begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    function automatic logic signed [COORD_BITS-1:0] pick_coord(input bit wide);
        if (wide)
            return COORD_BITS'($urandom);
        return COORD_BITS'(int'($urandom_range(0, 2000)) - 1000);
    endfunction

    function automatic void clear_stages();
        for (int lv = 0; lv < LEVELS; lv++)
            seen[lv] = ccs_pkg::SEEN_NONE;
    endfunction

    function automatic void reset_predictor();
        mode_cubic = 1'b1;
        for (int lv = 0; lv < LEVELS; lv++)
        begin
            tail_x[lv] = 0;
            tail_y[lv] = 0;
            head_x[lv] = 0;
            head_y[lv] = 0;
        end
        clear_stages();
    endfunction

    function automatic curve_pt_t make_pt(input longint x, input longint y, input bit last);
        curve_pt_t p;
        p.x    = x;
        p.y    = y;
        p.last = last;
        return p;
    endfunction

    function automatic void shift_in(input int lv, input curve_pt_t p);
        tail_x[lv] = head_x[lv];
        tail_y[lv] = head_y[lv];
        head_x[lv] = p.x;
        head_y[lv] = p.y;
    endfunction

    function automatic void subdivide_stage(input int lv, input curve_pt_t p,
                                            ref curve_pt_t q[$]);
        case (seen[lv])
            ccs_pkg::SEEN_ONE:
            begin
                if (p.last)
                begin
                    q.push_back(make_pt(p.x, p.y, 1'b1));
                    seen[lv] = ccs_pkg::SEEN_NONE;
                end
                else
                begin
                    q.push_back(make_pt((head_x[lv] + p.x) / 2, (head_y[lv] + p.y) / 2, 1'b0));
                    shift_in(lv, p);
                    seen[lv] = ccs_pkg::SEEN_MORE;
                end
            end
            ccs_pkg::SEEN_MORE:
            begin
                q.push_back(make_pt((tail_x[lv] + 6 * head_x[lv] + p.x) / 8,
                                    (tail_y[lv] + 6 * head_y[lv] + p.y) / 8, 1'b0));
                q.push_back(make_pt((head_x[lv] + p.x) / 2, (head_y[lv] + p.y) / 2, 1'b0));
                shift_in(lv, p);
                if (p.last)
                begin
                    q.push_back(make_pt(p.x, p.y, 1'b1));
                    seen[lv] = ccs_pkg::SEEN_NONE;
                end
            end
            default:
            begin
                q.push_back(p);
                if (p.last)
                    seen[lv] = ccs_pkg::SEEN_NONE;
                else
                begin
                    head_x[lv] = p.x;
                    head_y[lv] = p.y;
                    seen[lv] = ccs_pkg::SEEN_ONE;
                end
            end
        endcase
    endfunction

    function automatic void predict_curve_words(input logic signed [COORD_BITS-1:0] px,
                                                input logic signed [COORD_BITS-1:0] py,
                                                input logic pl);
        curve_pt_t   cur[$];
        curve_pt_t   nxt[$];
        curve_word_t w;
        cur.push_back(make_pt(longint'(px) * FRAC_SCALE, longint'(py) * FRAC_SCALE, pl));
        if (mode_cubic)
        begin
            for (int lv = 0; lv < LEVELS; lv++)
            begin
                nxt = {};
                foreach (cur[i])
                    subdivide_stage(lv, cur[i], nxt);
                cur = nxt;
            end
        end
        foreach (cur[i])
        begin
            w.x    = OUT_BITS'(cur[i].x);
            w.y    = OUT_BITS'(cur[i].y);
            w.last = cur[i].last;
            pending_words.push_back(w);
        end
    endfunction

    // Entered and left just after a rising edge
    task automatic send_point(input logic signed [COORD_BITS-1:0] px,
                              input logic signed [COORD_BITS-1:0] py,
                              input logic pl);
        int gap;
        gap = gaps_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        predict_curve_words(px, py, pl);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {py, px};
        s_axis_tlast  <= pl;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        points_sent++;
        if (pl)
            curves_sent++;
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input logic mode);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(posedge clk);
        cfg_we    <= 1'b0;
        mode_cubic = mode;
        clear_stages();
    endtask

    // Well-formed curves with random content, with some random end marks as noise
    task automatic send_random_points(input int count);
        int  left;
        bit  wide;
        bit  last;
        left = 0;
        wide = 1'b0;
        for (int i = 0; i < count; i++)
        begin
            if (left == 0)
            begin
                left = ($urandom_range(0, 99) < 15) ? $urandom_range(1, 2)
                                                    : $urandom_range(3, 8);
                wide = ($urandom_range(0, 3) == 0);
            end
            left--;
            last = (left == 0);
            if ($urandom_range(0, 9) == 0)
            begin
                last = ~last;
                if (last)
                    left = 0;
            end
            send_point(pick_coord(wide), pick_coord(wide), last);
        end
    endtask

    task automatic test_extremes();
        gaps_on  = 1'b1;
        stall_on <= 1'b1;
        send_point(16'sd32767, -16'sd32768, 1'b1);
        send_point(-16'sd32768, 16'sd32767, 1'b0);
        send_point(16'sd32767, -16'sd32768, 1'b1);
        send_point(16'sd0, 16'sd0, 1'b0);
        send_point(16'sd100, -16'sd50, 1'b0);
        send_point(-16'sd1, -16'sd1, 1'b1);
        send_point(-16'sd32768, -16'sd32768, 1'b0);
        send_point(16'sd32767, 16'sd32767, 1'b0);
        send_point(-16'sd32768, 16'sd32767, 1'b0);
        send_point(16'sd32767, -16'sd32768, 1'b0);
        send_point(16'sd0, 16'sd0, 1'b1);
    endtask

    task automatic test_mode_writes();
        // drop an open curve by switching modes
        send_point(16'sd7, 16'sd9, 1'b0);
        send_point(-16'sd300, 16'sd41, 1'b0);
        write_mode(1'b0);
        send_point(16'sd32767, 16'sd32767, 1'b0);
        send_point(-16'sd32768, -16'sd32768, 1'b1);
        send_point(16'sd5, -16'sd5, 1'b0);
        write_mode(1'b0);
        send_point(-16'sd1, 16'sd1, 1'b1);
        write_mode(1'b1);
        send_point(16'sd12, 16'sd34, 1'b0);
        write_mode(1'b1);
        send_point(16'sd1, 16'sd2, 1'b0);
        send_point(16'sd3, 16'sd4, 1'b0);
        send_point(-16'sd5, -16'sd6, 1'b1);
    endtask

    task automatic test_random_curves();
        gaps_on  = 1'b1;
        stall_on <= 1'b1;
        send_random_points(35);
        write_mode(1'b0);
        send_random_points(12);
        write_mode(1'b1);
        gaps_on  = 1'b0;
        stall_on <= 1'b0;
        send_random_points(25);
    endtask

    task automatic test_backpressure();
        gaps_on  = 1'b0;
        stall_on <= 1'b0;
        hold_reqs <= hold_reqs + 1;
        send_random_points(16);
        wait_idle();
        gaps_on  = 1'b1;
        stall_on <= 1'b1;
        send_random_points(4);
    endtask

    // Output side: random ready pattern plus long holds on request
    initial
    begin : sink
        int  run_left;
        int  hold_left;
        int  holds_taken;
        bit  ready_now;
        m_axis_tready = 1'b0;
        run_left    = 0;
        hold_left   = 0;
        holds_taken = 0;
        ready_now   = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_left == 0 && holds_taken != hold_reqs)
            begin
                holds_taken = hold_reqs;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                ready_now = 1'b0;
            end
            else if (!stall_on)
                ready_now = 1'b1;
            else if (run_left > 0)
                run_left--;
            else if (ready_now)
            begin
                ready_now = 1'b0;
                run_left  = pick_gap();
            end
            else
            begin
                ready_now = 1'b1;
                run_left  = $urandom_range(0, 15);
            end
            m_axis_tready <= ready_now;
        end
    end

    always @(posedge clk)
    begin : check_words
        curve_word_t want;
        logic signed [OUT_BITS-1:0] got_x;
        logic signed [OUT_BITS-1:0] got_y;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_x = m_axis_tdata[OUT_BITS-1:0];
            got_y = m_axis_tdata[2*OUT_BITS-1:OUT_BITS];
            if (pending_words.size() == 0)
            begin
                errors++;
                $display("%0t: expected no word, got x=%0d y=%0d last=%0b",
                         $time, got_x, got_y, m_axis_tlast);
            end
            else
            begin
                want = pending_words.pop_front();
                words_checked++;
                if (got_x !== want.x || got_y !== want.y || m_axis_tlast !== want.last)
                begin
                    errors++;
                    $display("%0t: word %0d expected x=%0d y=%0d last=%0b,",
                             $time, words_checked, want.x, want.y, want.last);
                    $display("%0t: word %0d got x=%0d y=%0d last=%0b",
                             $time, words_checked, got_x, got_y, m_axis_tlast);
                end
            end
        end
    end

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        stall_on      = 1'b0;
        hold_reqs     = 0;
        gaps_on       = 1'b0;
        points_sent   = 0;
        curves_sent   = 0;
        words_checked = 0;
        errors        = 0;
        reset_predictor();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        test_mode_writes();
        test_random_curves();
        test_backpressure();

        wait_idle();
        $display("Covered %0d points in %0d closed curves, %0d curve words checked,",
                 points_sent, curves_sent, words_checked);
        $display("both modes, open curves cut by mode writes, and a long output hold.");
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/ccs_pkg.sv
hdl/ccs_cell.sv
hdl/cubic_curve_subdivider.sv
verif/tb_top.sv
